// File: rtl/dimmer_uart_frame_receiver_top_assert.svh
`ifndef DIMMER_UART_FRAME_RECEIVER_TOP_ASSERT_SVH
`define DIMMER_UART_FRAME_RECEIVER_TOP_ASSERT_SVH

// The expression holds at every clock edge.
`define DUFR_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define DUFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dufr_pkg.sv
package dufr_pkg;

	localparam int PAYLOAD_DEPTH_DEF = 32;

	localparam int GAP_W   = 21;
	localparam int IDLE_W  = 16;
	localparam int POLL_W  = 20;
	localparam int CFG_W   = 20;
	localparam int NUM_W   = 20;
	localparam int RAW_W   = 32;
	localparam int PVAL_W  = 16;

	localparam logic [GAP_W-1:0]  GAP_MAX       = {GAP_W{1'b1}};
	localparam logic [IDLE_W-1:0] IDLE_GAP_RST  = 16'd600;
	localparam logic [POLL_W-1:0] POLL_RST      = 20'd10000;
	localparam logic [NUM_W-1:0]  POWER_NUM     = 20'd1000000;
	localparam logic [7:0]        START_BYTE    = 8'h01;
	localparam logic [7:0]        CMD_POWER     = 8'h10;

	// Configuration register indexes.
	localparam logic REG_IDLE_GAP = 1'b0;
	localparam logic REG_POLL     = 1'b1;

	// Input action codes.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Event kinds of a result word.
	localparam logic EV_FRAME = 1'b0;
	localparam logic EV_POLL  = 1'b1;

	typedef enum logic [2:0] {
		ST_START = 3'd0,
		ST_ID    = 3'd1,
		ST_CMD   = 3'd2,
		ST_LEN   = 3'd3,
		ST_DATA  = 3'd4,
		ST_CHK1  = 3'd5,
		ST_CHK2  = 3'd6
	} parse_state_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        cmd;
		logic [7:0]        id;
		logic [7:0]        len;
		logic              pv;
		logic [PVAL_W-1:0] pval;
	} res_t;

	// Parser to top: what the current word produced.
	typedef struct packed {
		logic res_valid;
		logic div_start;
	} parse_ctl_t;

endpackage

// File: rtl/dimmer_uart_frame_receiver_top.sv
// Result path: a word that completes a result is registered in the pending word
// and then in the output register; a power frame with a nonzero raw value first
// goes through the bit-serial 1000000 / raw divider, and the input stalls meanwhile.
// Throughput: words that give no result are taken every cycle while no result is
// pending or in the divider; a word with a result stalls the input until it leaves the pending word.
// Reset: asynchronous, active low; clears parser, payload, gap counter, queues.
`include "dimmer_uart_frame_receiver_top_assert.svh"

module dimmer_uart_frame_receiver_top #(
	parameter int PAYLOAD_DEPTH = dufr_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [dufr_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        event_kind,
	output logic [7:0]                  frame_cmd,
	output logic [7:0]                  frame_id,
	output logic [7:0]                  frame_len,
	output logic                        power_valid,
	output logic [dufr_pkg::PVAL_W-1:0] power_value
);
	import dufr_pkg::*;

	logic [IDLE_W-1:0] idle_gap_q;
	logic [POLL_W-1:0] poll_q;

	logic              acc;
	parse_ctl_t        ctl;
	res_t              res;
	logic [RAW_W-1:0]  raw;
	logic              div_done;
	logic [PVAL_W-1:0] quotient;

	res_t              pend_q, out_q;
	logic              pend_valid_q, div_wait_q, out_valid_q;
	logic              pend_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_gap_q <= IDLE_GAP_RST;
			poll_q     <= POLL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IDLE_GAP: idle_gap_q <= cfg_data[IDLE_W-1:0];
				REG_POLL:     poll_q     <= cfg_data[POLL_W-1:0];
				default:      ;
			endcase
		end
	end

	assign in_stall  = div_wait_q || pend_valid_q;
	assign acc       = in_valid && !in_stall;
	assign pend_move = pend_valid_q && (!out_valid_q || !out_stall);

	dufr_parse #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.action   (action),
		.rx_byte  (rx_byte),
		.idle_gap (idle_gap_q),
		.poll_int (poll_q),
		.ctl      (ctl),
		.res      (res),
		.raw      (raw)
	);

	dufr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.divisor  (raw),
		.done     (div_done),
		.quotient (quotient)
	);

	// The pending word parts the parser from the output register, so input words are
	// still taken while a result waits downstream, until a second result is pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			div_wait_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.div_start)
				div_wait_q <= 1'b1;
			else if (div_done)
				div_wait_q <= 1'b0;

			if (ctl.res_valid || div_done)
				pend_valid_q <= 1'b1;
			else if (pend_move)
				pend_valid_q <= 1'b0;

			if (pend_move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_valid || ctl.div_start)
			pend_q <= res;
		else if (div_done)
			pend_q.pval <= quotient;
		if (pend_move)
			out_q <= pend_q;
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = out_q.kind;
	assign frame_cmd   = out_q.cmd;
	assign frame_id    = out_q.id;
	assign frame_len   = out_q.len;
	assign power_valid = out_q.pv;
	assign power_value = out_q.pval;

	`DUFR_ASSERT_ALWAYS(a_wait_excl, !(div_wait_q && pend_valid_q), "divider busy with a pending word")
	`DUFR_ASSERT_ALWAYS(a_done_in_wait, !div_done || div_wait_q, "divider done while not waiting")
	`DUFR_ASSERT_NEXT(a_pend_moves, pend_valid_q && !out_valid_q, out_valid_q, "pending word not moved to output")

endmodule

// File: rtl/dufr_div.sv
module dufr_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [dufr_pkg::RAW_W-1:0] divisor,
	output logic                     done,
	output logic [dufr_pkg::PVAL_W-1:0] quotient
);
	import dufr_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	// Restoring divider, one quotient bit per cycle. The numerator register
	// shifts out dividend bits at the top and takes quotient bits at the bottom.
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] rem_q;
	logic [RAW_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_W:0]   sh;
	logic             ge;
	logic [NUM_W-1:0] diff;

	always_comb begin
		sh   = {rem_q, num_q[NUM_W-1]};
		ge   = {{(RAW_W-NUM_W-1){1'b0}}, sh} >= div_q;
		diff = sh[NUM_W-1:0] - div_q[NUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= POWER_NUM;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff : sh[NUM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q[PVAL_W-1:0];

endmodule

// File: rtl/dufr_parse.sv
module dufr_parse #(
	parameter int PAYLOAD_DEPTH = dufr_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         action,
	input  logic [7:0]                   rx_byte,
	input  logic [dufr_pkg::IDLE_W-1:0]  idle_gap,
	input  logic [dufr_pkg::POLL_W-1:0]  poll_int,
	output dufr_pkg::parse_ctl_t         ctl,
	output dufr_pkg::res_t               res,
	output logic [dufr_pkg::RAW_W-1:0]   raw
);
	import dufr_pkg::*;

	localparam int IDX_W = $clog2(PAYLOAD_DEPTH);

	parse_state_t     state_q, state_d, st_eff;
	logic [15:0]      sum_q, sum_d, sum_m1;
	logic [7:0]       id_q, id_d, cmd_q, cmd_d, len_q, len_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W:0]   idx_inc;
	logic [IDX_W-1:0] idx_nxt;
	logic [RAW_W-1:0] raw_q, raw_d;
	logic [GAP_W-1:0] gap_q, gap_d, gap_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			sum_q   <= '0;
			id_q    <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			raw_q   <= '0;
			gap_q   <= '0;
		end else begin
			state_q <= state_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			raw_q   <= raw_d;
			gap_q   <= gap_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sum_d   = sum_q;
		id_d    = id_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		idx_d   = idx_q;
		raw_d   = raw_q;
		gap_d   = gap_q;
		ctl     = '0;
		res     = '0;
		sum_m1  = sum_q - 16'd1;
		gap_inc = (gap_q == GAP_MAX) ? gap_q : gap_q + GAP_W'(1);
		idx_inc = {1'b0, idx_q} + (IDX_W+1)'(1);
		idx_nxt = (idx_inc > (IDX_W+1)'(PAYLOAD_DEPTH-1)) ? '0 : idx_inc[IDX_W-1:0];
		// A byte after a long silence restarts the hunt for the start byte.
		st_eff  = (gap_q > GAP_W'(idle_gap)) ? ST_START : state_q;

		if (acc) begin
			if (action == ACT_TICK) begin
				if (gap_inc > GAP_W'(poll_int)) begin
					gap_d         = '0;
					ctl.res_valid = 1'b1;
					res.kind      = EV_POLL;
				end else begin
					gap_d = gap_inc;
				end
			end else begin
				gap_d = '0;
				unique case (st_eff)
					ST_ID: begin
						id_d    = rx_byte;
						sum_d   = sum_q + 16'(rx_byte);
						state_d = ST_CMD;
					end
					ST_CMD: begin
						cmd_d   = rx_byte;
						sum_d   = sum_q + 16'(rx_byte);
						state_d = ST_LEN;
					end
					ST_LEN: begin
						len_d   = rx_byte;
						idx_d   = '0;
						sum_d   = sum_q + 16'(rx_byte);
						state_d = (rx_byte == 8'd0) ? ST_CHK1 : ST_DATA;
					end
					ST_DATA: begin
						// Only payload bytes at indexes four to seven are kept, in raw.
						for (int k = 0; k < 4; k++) begin
							if (idx_q == IDX_W'(4 + k))
								raw_d[8*k +: 8] = rx_byte;
						end
						idx_d = idx_nxt;
						sum_d = sum_q + 16'(rx_byte);
						if (8'(idx_nxt) == len_q)
							state_d = ST_CHK1;
					end
					ST_CHK1: begin
						sum_d   = sum_m1;
						state_d = (sum_m1[15:8] == rx_byte) ? ST_CHK2 : ST_START;
					end
					ST_CHK2: begin
						state_d = ST_START;
						if (sum_q[7:0] == rx_byte) begin
							res.kind = EV_FRAME;
							res.cmd  = cmd_q;
							res.id   = id_q;
							res.len  = len_q;
							if (cmd_q == CMD_POWER) begin
								res.pv = 1'b1;
								if (raw_q == '0)
									ctl.res_valid = 1'b1;
								else
									ctl.div_start = 1'b1;
							end else begin
								ctl.res_valid = 1'b1;
							end
						end
					end
					default: begin
						state_d = ST_START;
						if (rx_byte == START_BYTE) begin
							sum_d   = 16'(START_BYTE);
							state_d = ST_ID;
						end
					end
				endcase
			end
		end
	end

	assign raw = raw_q;

endmodule

// File: bench/tb_dimmer_uart_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_dimmer_uart_frame_receiver_top;
	import dufr_pkg::*;

	localparam int DEPTH          = PAYLOAD_DEPTH_DEF;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 160;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int POLL_ROWS      = 27;
	localparam int SCRIPT_ROWS    = 30;

	typedef enum logic [1:0] {FR_GOOD, FR_BAD_CSUM, FR_CUT, FR_LONG} frame_mode_t;

	typedef struct packed {
		logic       act;
		logic [7:0] b;
		logic       typed;
		logic       has_res;
		res_t       want;
	} step_row_t;

	localparam res_t NO_EVENT   = '0;
	localparam res_t POLL_EVENT = '{EV_POLL, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000};

	// Every row steps the predictor; rows with typed set carry their own expectation.
	localparam step_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{ACT_TICK, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h55, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h01, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'hFF, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'hFF, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h01, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'hFE, 1'b1, 1'b1,
			'{EV_FRAME, 8'hFF, 8'hFF, 8'h00, 1'b0, 16'h0000}},
		'{ACT_BYTE, 8'h01, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h10, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h10, 1'b1, 1'b1,
			'{EV_FRAME, 8'h10, 8'h00, 8'h00, 1'b1, 16'h0000}},
		'{ACT_BYTE, 8'h01, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h22, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h33, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'hFF, 1'b1, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h01, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h33, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h20, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h02, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'hAA, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h55, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h01, 1'b0, 1'b0, NO_EVENT},
		'{ACT_BYTE, 8'h54, 1'b0, 1'b0, NO_EVENT},
		'{ACT_TICK, 8'hA5, 1'b1, 1'b1, POLL_EVENT},
		'{ACT_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
		'{ACT_TICK, 8'h5A, 1'b1, 1'b1, POLL_EVENT}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_IDLE_GAP;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACT_BYTE;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              event_kind;
	logic [7:0]        frame_cmd;
	logic [7:0]        frame_id;
	logic [7:0]        frame_len;
	logic              power_valid;
	logic [PVAL_W-1:0] power_value;

	// Predictor state.
	parse_state_t      hunt_state;
	logic [15:0]       csum;
	logic [7:0]        frm_id;
	logic [7:0]        frm_cmd;
	logic [7:0]        frm_len;
	int                wr_ptr;
	logic [7:0]        payload [DEPTH];
	logic [GAP_W-1:0]  tick_gap;
	logic [IDLE_W-1:0] idle_limit;
	logic [POLL_W-1:0] poll_limit;

	res_t pending_events [$];
	int   mismatches = 0;
	int   words_sent = 0;
	int   idle_odds = 6;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	dimmer_uart_frame_receiver_top u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic parse_word(input logic act, input logic [7:0] b, output res_t r);
		logic [31:0] raw;
		r = '0;
		if (act == ACT_TICK) begin
			if (tick_gap != GAP_MAX)
				tick_gap = tick_gap + 1'b1;
			if (tick_gap > poll_limit) begin
				tick_gap = '0;
				r.kind = EV_POLL;
				return 1'b1;
			end
			return 1'b0;
		end
		if (tick_gap > idle_limit)
			hunt_state = ST_START;
		tick_gap = '0;
		case (hunt_state)
			ST_ID: begin
				frm_id = b;
				csum = csum + 16'(b);
				hunt_state = ST_CMD;
			end
			ST_CMD: begin
				frm_cmd = b;
				csum = csum + 16'(b);
				hunt_state = ST_LEN;
			end
			ST_LEN: begin
				frm_len = b;
				wr_ptr = 0;
				csum = csum + 16'(b);
				hunt_state = (b == 8'h00) ? ST_CHK1 : ST_DATA;
			end
			ST_DATA: begin
				payload[wr_ptr] = b;
				wr_ptr++;
				csum = csum + 16'(b);
				if (wr_ptr > DEPTH - 1)
					wr_ptr = 0;
				// A length of DEPTH or more never matches the wrapped index.
				if (wr_ptr == int'(frm_len))
					hunt_state = ST_CHK1;
			end
			ST_CHK1: begin
				csum = csum - 16'd1;
				hunt_state = (csum[15:8] == b) ? ST_CHK2 : ST_START;
			end
			ST_CHK2: begin
				hunt_state = ST_START;
				if (csum[7:0] == b) begin
					r.kind = EV_FRAME;
					r.cmd = frm_cmd;
					r.id = frm_id;
					r.len = frm_len;
					if (frm_cmd == CMD_POWER) begin
						raw = {payload[7], payload[6], payload[5], payload[4]};
						r.pv = 1'b1;
						r.pval = (raw == '0) ? '0 : PVAL_W'(32'(POWER_NUM) / raw);
					end
					return 1'b1;
				end
			end
			default: begin
				hunt_state = ST_START;
				if (b == START_BYTE) begin
					csum = 16'(START_BYTE);
					hunt_state = ST_ID;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic put_word(input logic act, input logic [7:0] b, input logic typed,
		input logic typed_has, input res_t typed_res);
		res_t r;
		logic got;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
		got = parse_word(act, b, r);
		if (typed) begin
			got = typed_has;
			r = typed_res;
		end
		if (got)
			pending_events.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b);
		put_word(ACT_BYTE, b, 1'b0, 1'b0, NO_EVENT);
	endtask

	task automatic send_tick();
		put_word(ACT_TICK, 8'($urandom), 1'b0, 1'b0, NO_EVENT);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input logic [IDLE_W-1:0] ig, input logic [POLL_W-1:0] pl);
		cfg_we <= 1'b1;
		cfg_index <= REG_IDLE_GAP;
		// The upper bits of the idle gap word are don't-care.
		cfg_data <= {(CFG_W - IDLE_W)'($urandom), ig};
		@(posedge clk);
		cfg_index <= REG_POLL;
		cfg_data <= pl;
		@(posedge clk);
		cfg_we <= 1'b0;
		idle_limit = ig;
		poll_limit = pl;
	endtask

	task automatic send_frame(input frame_mode_t mode);
		logic [7:0]  body [$];
		logic [15:0] sum;
		logic [31:0] raw;
		logic [7:0]  flen;
		logic [7:0]  fcmd;
		int          n;
		fcmd = ($urandom_range(0, 1) == 0) ? CMD_POWER : 8'($urandom);
		if (mode == FR_LONG)
			flen = 8'($urandom_range(DEPTH, 255));
		else if ($urandom_range(0, 5) == 0)
			flen = 8'($urandom_range(13, DEPTH - 1));
		else
			flen = 8'($urandom_range(0, 12));
		case ($urandom_range(0, 3))
			0: raw = '0;
			1: raw = $urandom_range(1, 64);
			2: raw = $urandom_range(1, 1000000);
			default: raw = $urandom;
		endcase
		body.push_back(START_BYTE);
		body.push_back(8'($urandom));
		body.push_back(fcmd);
		body.push_back(flen);
		n = (mode == FR_LONG) ? $urandom_range(DEPTH - 4, DEPTH + 8) : int'(flen);
		for (int i = 0; i < n; i++)
			body.push_back((i >= 4 && i < 8) ? raw[8 * (i - 4) +: 8] : 8'($urandom));
		sum = '0;
		foreach (body[i])
			sum = sum + 16'(body[i]);
		sum = sum - 16'd1;
		if (mode == FR_BAD_CSUM)
			sum = sum ^ (16'd1 << $urandom_range(0, 15));
		if (mode != FR_LONG) begin
			body.push_back(sum[15:8]);
			body.push_back(sum[7:0]);
		end
		n = (mode == FR_CUT) ? $urandom_range(2, body.size() - 1) : body.size();
		for (int i = 0; i < n; i++) begin
			if (i != 0 && $urandom_range(0, 24) == 0)
				repeat ($urandom_range(1, 2)) send_tick();
			send_byte(body[i]);
		end
		// An overlong frame can only be left through a gap of silence.
		if (mode == FR_LONG)
			repeat (int'(idle_limit) + $urandom_range(1, 3)) send_tick();
	endtask

	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				burst = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {event_kind, frame_cmd, frame_id, frame_len, power_valid, power_value};
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word kind %0d cmd %02h id %02h len %02h pv %0d power %0d",
						$time, seen.kind, seen.cmd, seen.id, seen.len, seen.pv, seen.pval);
			end else begin
				want = pending_events.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected kind %0d cmd %02h id %02h len %02h pv %0d power %0d",
							$time, want.kind, want.cmd, want.id, want.len, want.pv, want.pval);
						$display("%0t:      got kind %0d cmd %02h id %02h len %02h pv %0d power %0d",
							$time, seen.kind, seen.cmd, seen.id, seen.len, seen.pv, seen.pval);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [IDLE_W-1:0] ig;
		logic [POLL_W-1:0] pl;
		int                pick;
		int                phase_end;
		hunt_state = ST_START;
		csum = '0;
		frm_id = '0;
		frm_cmd = '0;
		frm_len = '0;
		wr_ptr = 0;
		foreach (payload[i])
			payload[i] = '0;
		tick_gap = '0;
		idle_limit = IDLE_GAP_RST;
		poll_limit = POLL_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (i == POLL_ROWS) begin
				drain();
				set_limits(IDLE_GAP_RST, '0);
			end
			put_word(SCRIPT[i].act, SCRIPT[i].b, SCRIPT[i].typed, SCRIPT[i].has_res,
				SCRIPT[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin ig = IDLE_GAP_RST; pl = POLL_RST; idle_odds = 4; end
				1: begin ig = '0; pl = '0; idle_odds = 8; end
				2: begin ig = '1; pl = '1; idle_odds = 0; end
				3: begin ig = 16'd5; pl = 20'd20; idle_odds = 3; end
				PRESSURE_PHASE: begin ig = IDLE_GAP_RST; pl = '0; idle_odds = 6; end
				5: begin
					ig = 16'($urandom_range(0, 20));
					pl = 20'($urandom_range(0, 60));
					idle_odds = 0;
				end
				6: begin ig = 16'd3; pl = 20'd7; idle_odds = 5; end
				default: begin
					ig = 16'($urandom_range(0, 30));
					pl = 20'($urandom_range(0, 40));
					idle_odds = 0;
				end
			endcase
			set_limits(ig, pl);
			// The output side holds off while every tick raises a poll word, so the
			// block backs up and stalls its input.
			if (ph == PRESSURE_PHASE)
				hold_left = HOLD_CYCLES;
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					send_frame(FR_GOOD);
				end else if (pick < 65) begin
					send_frame(FR_BAD_CSUM);
				end else if (pick < 72) begin
					send_frame(FR_CUT);
				end else if (pick < 80) begin
					repeat ($urandom_range(1, 4))
						send_byte(($urandom_range(0, 3) == 0) ? START_BYTE : 8'($urandom));
				end else if (pick < 95 || idle_limit > 16'd40) begin
					if (idle_limit < 16'd100 && $urandom_range(0, 3) == 0)
						repeat (int'(idle_limit) + 1) send_tick();
					else
						repeat ($urandom_range(1, 6)) send_tick();
				end else begin
					send_frame(FR_LONG);
				end
			end
		end

		drain();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: dimmer_uart_frame_receiver_top.f
+incdir+rtl
rtl/dufr_pkg.sv
rtl/dufr_div.sv
rtl/dufr_parse.sv
rtl/dimmer_uart_frame_receiver_top.sv
bench/tb_dimmer_uart_frame_receiver_top.sv
